>>> design/wed_pkg.sv
`timescale 1ns / 1ps

package wed_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int SYM_W       = 21;
    localparam int VAL_W       = 20;
    localparam int COST_W      = 8;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int CFG_ADDR_W  = 2;
    localparam int S_TDATA_W   = ((SYM_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VAL_W + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_TARGET = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_DIST = 2'd0,
        CFG_INS_COST = 2'd1,
        CFG_DEL_COST = 2'd2,
        CFG_SUB_COST = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COST_W-1:0] ins;
        logic [COST_W-1:0] del;
        logic [COST_W-1:0] sub;
    } t_costs;

    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] min2(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

endpackage

>>> design/wed_cell.sv
`timescale 1ns / 1ps

// One dynamic-programming cell: cheapest of the left, above and diagonal steps.
module wed_cell
    import wed_pkg::*;
(
    input  t_costs             i_costs,
    input  logic [VAL_W-1:0]   i_left,
    input  logic [VAL_W-1:0]   i_above,
    input  logic [VAL_W-1:0]   i_diag,
    input  logic               i_match,
    output logic [VAL_W-1:0]   o_cell
);

    logic [VAL_W-1:0] w_from_left;
    logic [VAL_W-1:0] w_from_above;
    logic [VAL_W-1:0] w_from_diag;
    logic [COST_W-1:0] w_sub;

    always_comb begin
        w_sub        = i_match ? '0 : i_costs.sub;
        w_from_left  = sat_add(i_left, VAL_W'(i_costs.del));
        w_from_above = sat_add(i_above, VAL_W'(i_costs.ins));
        w_from_diag  = sat_add(i_diag, VAL_W'(w_sub));
        o_cell       = min2(min2(w_from_left, w_from_above), w_from_diag);
    end

endmodule

>>> design/weighted_edit_distance_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                         Contents
// s        in   i_s_tvalid/o_s_tready           tuser: req_type; tdata: symbol
// m        out  o_m_tvalid/i_m_tready           tdata: distance; tuser: cut_off, overflow
// cfg      in   i_cfg_valid/o_cfg_ready         i_cfg_addr: register, i_cfg_data: value
//
// Load, finish and no-op items are accepted in S_IDLE. A target item runs through accept,
// a read-ahead state (S_PREP), one cell of the row per cycle through the shared cell unit
// (S_CELL), and a closing write/minimum state (S_LAST).
// The source and row memories need no clearing: the first row is generated on the fly.
// Reset is synchronous, active low. A finish waits for idle and while a result is still held.
module weighted_edit_distance_top
    import wed_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // stream in
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [S_TDATA_W-1:0]    i_s_tdata,   // [20:0] symbol
    input  logic [1:0]              i_s_tuser,   // [1:0] req_type
    // stream out
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [M_TDATA_W-1:0]    o_m_tdata,   // [19:0] distance
    output logic [1:0]              o_m_tuser,   // [0] cut_off, [1] source_overflow
    // configuration
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [VAL_W-1:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_CELL = 4'b0100,
        S_LAST = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [VAL_W-1:0]  r_max_dist;
    t_costs            r_costs;

    logic [SYM_W-1:0]  r_src_mem [MAX_LEN];
    logic [VAL_W-1:0]  r_row_mem [MAX_LEN];
    logic [SYM_W-1:0]  r_src_q;
    logic [VAL_W-1:0]  r_row_q;

    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_j;
    logic              r_first;
    logic              r_started;
    logic              r_stopped;
    logic              r_ovf;
    logic [VAL_W-1:0]  r_col0;
    logic [VAL_W-1:0]  r_cur;
    logic [VAL_W-1:0]  r_diag;
    logic [VAL_W-1:0]  r_min;
    logic [VAL_W-1:0]  r_last;
    logic [SYM_W-1:0]  r_sym;

    logic              r_ovalid;
    logic [VAL_W-1:0]  r_dist;
    logic              r_cut;
    logic              r_sovf;

    logic              w_accept;
    t_req              w_req;
    logic [SYM_W-1:0]  w_sym;
    logic [CNT_W-1:0]  w_j_next;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_row_we;
    logic [ADDR_W-1:0] w_row_waddr;
    logic [VAL_W-1:0]  w_above;
    logic [VAL_W-1:0]  w_cell;
    logic [VAL_W-1:0]  w_cur_init;
    logic [VAL_W-1:0]  w_final_min;
    logic [VAL_W-1:0]  w_dist;
    logic              w_out_free;

    assign w_req      = t_req'(i_s_tuser);
    assign w_sym      = i_s_tdata[SYM_W-1:0];
    assign w_out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && (w_req != REQ_FINISH || w_out_free);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = M_TDATA_W'(r_dist);
    assign o_m_tuser  = {r_sovf, r_cut};

    assign w_j_next    = CNT_W'(r_j) + CNT_W'(1);
    assign w_rd_addr   = (r_state == S_PREP) ? '0 : w_j_next[ADDR_W-1:0];
    assign w_above     = r_first ? VAL_W'(w_j_next) : r_row_q;
    assign w_cur_init  = sat_add(r_col0, VAL_W'(1));
    assign w_final_min = min2(r_min, r_cur);

    // Row entry k (k >= 1) lives at address k-1; entry zero is r_col0.
    always_comb begin
        w_row_we    = 1'b0;
        w_row_waddr = '0;
        case (r_state)
            S_CELL: begin
                w_row_we    = (r_j != '0);
                w_row_waddr = r_j - ADDR_W'(1);
            end
            S_LAST: begin
                w_row_we    = (r_cnt != '0);
                w_row_waddr = ADDR_W'(r_cnt - CNT_W'(1));
            end
            default: begin
                w_row_we    = 1'b0;
                w_row_waddr = '0;
            end
        endcase
    end

    always_comb begin
        w_dist = r_started ? r_last : VAL_W'(r_cnt);
        if (r_max_dist != '0 && w_dist > r_max_dist) begin
            w_dist = r_max_dist;
        end
    end

    wed_cell u_cell (
        .i_costs (r_costs),
        .i_left  (r_cur),
        .i_above (w_above),
        .i_diag  (r_diag),
        .i_match (r_src_q == r_sym),
        .o_cell  (w_cell)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept && w_req == REQ_LOAD && !r_started && !r_stopped
            && r_cnt < CNT_W'(MAX_LEN)) begin
            r_src_mem[r_cnt[ADDR_W-1:0]] <= w_sym;
        end
        if (w_row_we) begin
            r_row_mem[w_row_waddr] <= r_cur;
        end
        r_src_q <= r_src_mem[w_rd_addr];
        r_row_q <= r_row_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_req == REQ_TARGET && !r_stopped) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:  n_state = (r_cnt == '0) ? S_LAST : S_CELL;
            S_CELL:  n_state = (w_j_next == r_cnt) ? S_LAST : S_CELL;
            S_LAST:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max_dist <= '0;
            r_costs    <= '{ins: COST_W'(1), del: COST_W'(1), sub: COST_W'(1)};
            r_cnt      <= '0;
            r_started  <= 1'b0;
            r_stopped  <= 1'b0;
            r_ovf      <= 1'b0;
            r_col0     <= '0;
            r_last     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_MAX_DIST: r_max_dist  <= i_cfg_data;
                    CFG_INS_COST: r_costs.ins <= i_cfg_data[COST_W-1:0];
                    CFG_DEL_COST: r_costs.del <= i_cfg_data[COST_W-1:0];
                    CFG_SUB_COST: r_costs.sub <= i_cfg_data[COST_W-1:0];
                    default: ;
                endcase
            end

            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_req)
                            REQ_LOAD: begin
                                // drop late or stopped loads
                                if (!r_started && !r_stopped) begin
                                    if (r_cnt < CNT_W'(MAX_LEN)) begin
                                        r_cnt <= r_cnt + CNT_W'(1);
                                    end else begin
                                        r_ovf <= 1'b1;
                                    end
                                end
                            end
                            REQ_TARGET: begin
                                if (!r_stopped) begin
                                    r_started <= 1'b1;
                                end
                            end
                            REQ_FINISH: begin
                                r_ovalid  <= 1'b1;
                                r_cnt     <= '0;
                                r_started <= 1'b0;
                                r_stopped <= 1'b0;
                                r_ovf     <= 1'b0;
                                r_col0    <= '0;
                                r_last    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PREP: begin
                    r_col0 <= w_cur_init;
                end
                S_LAST: begin
                    r_last <= r_cur;
                    if (r_max_dist != '0 && w_final_min > r_max_dist) begin
                        r_stopped <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_req == REQ_TARGET) begin
                    r_sym   <= w_sym;
                    r_first <= !r_started;
                end
                if (w_accept && w_req == REQ_FINISH) begin
                    r_dist <= w_dist;
                    r_cut  <= r_stopped;
                    r_sovf <= r_ovf;
                end
            end
            S_PREP: begin
                r_cur  <= w_cur_init;
                r_diag <= r_col0;
                r_min  <= w_cur_init;
                r_j    <= '0;
            end
            S_CELL: begin
                r_min  <= min2(r_min, r_cur);
                r_cur  <= w_cell;
                r_diag <= w_above;
                r_j    <= r_j + ADDR_W'(1);
            end
            default: ;
        endcase
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wed_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 1100;
    localparam int ROW_IDX_MAX   = 2047;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PRINT_CAP     = 40;
    localparam int HI_W          = VAL_W - COST_W;

    localparam logic [SYM_W-1:0] SYM_ALL = {SYM_W{1'b1}};

    typedef struct packed {
        logic [VAL_W-1:0] distance;
        logic             cut;
        logic             over;
    } t_distance_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [1:0]            i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [VAL_W-1:0]      i_cfg_data  = '0;

    weighted_edit_distance_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // distance predictor state
    logic [SYM_W-1:0]  src_syms [MAX_LEN];
    logic [VAL_W-1:0]  dp_row [MAX_LEN+1];
    int unsigned       src_len     = 0;
    int unsigned       rows_done   = 0;
    logic [VAL_W-1:0]  corner_cell = '0;
    bit                halted      = 1'b0;
    bit                src_dropped = 1'b0;
    logic [VAL_W-1:0]  lim_dist    = '0;
    logic [COST_W-1:0] c_ins       = 8'd1;
    logic [COST_W-1:0] c_del       = 8'd1;
    logic [COST_W-1:0] c_sub       = 8'd1;

    t_distance_result dist_q [$];

    int  errors          = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  cutoffs_seen    = 0;
    int  overflows_seen  = 0;
    int  reg_writes      = 0;
    int  ready_hold      = 0;
    bit  calm            = 1'b0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d distances outstanding", CYCLE_LIMIT,
                 dist_q.size());
        $display("weighted_edit_distance_top regression: fail");
        $finish;
    end

    function automatic logic [VAL_W-1:0] clamp_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        int unsigned s;
        s = a + b;
        return (s > VAL_MAX) ? VAL_MAX : s[VAL_W-1:0];
    endfunction

    function automatic void clear_job();
        src_len     = 0;
        rows_done   = 0;
        corner_cell = '0;
        halted      = 1'b0;
        src_dropped = 1'b0;
    endfunction

    function automatic void fold_target(logic [SYM_W-1:0] sym);
        logic [VAL_W-1:0]  cur, diag, above, x, alt, rmin;
        logic [COST_W-1:0] step;
        // first row is generated fresh on the first target of a job
        if (rows_done == 0)
            for (int j = 0; j <= src_len; j++) dp_row[j] = VAL_W'(j);
        cur  = clamp_add(dp_row[0], VAL_W'(1));
        diag = dp_row[0];
        x    = cur;
        for (int j = 0; j < src_len; j++) begin
            step  = (src_syms[j] == sym) ? '0 : c_sub;
            above = dp_row[j+1];
            x     = clamp_add(cur, VAL_W'(c_del));
            alt   = clamp_add(above, VAL_W'(c_ins));
            if (alt < x) x = alt;
            alt   = clamp_add(diag, VAL_W'(step));
            if (alt < x) x = alt;
            dp_row[j] = cur;
            cur       = x;
            diag      = above;
        end
        dp_row[src_len] = x;
        corner_cell     = x;
        if (rows_done < ROW_IDX_MAX) rows_done++;
        if (lim_dist != 0) begin
            rmin = dp_row[0];
            for (int j = 1; j <= src_len; j++)
                if (dp_row[j] < rmin) rmin = dp_row[j];
            if (rmin > lim_dist) halted = 1'b1;
        end
    endfunction

    function automatic void model_item(t_req req, logic [SYM_W-1:0] sym);
        t_distance_result r;
        logic [VAL_W-1:0] d;
        case (req)
            REQ_LOAD: begin
                if (rows_done == 0 && !halted) begin
                    if (src_len < MAX_LEN) begin
                        src_syms[src_len] = sym;
                        src_len++;
                    end else begin
                        src_dropped = 1'b1;
                    end
                end
            end
            REQ_TARGET: begin
                if (!halted) fold_target(sym);
            end
            REQ_FINISH: begin
                d = (rows_done != 0) ? corner_cell : VAL_W'(src_len);
                if (lim_dist != 0 && d > lim_dist) d = lim_dist;
                r.distance = d;
                r.cut      = halted;
                r.over     = src_dropped;
                dist_q.push_back(r);
                if (halted) cutoffs_seen++;
                if (src_dropped) overflows_seen++;
                clear_job();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int send_gap();
        if (calm || $urandom_range(0, 99) < 60) return 0;
        return idle_len();
    endfunction

    function automatic logic [SYM_W-1:0] pick_sym(logic [SYM_W-1:0] base, bit wide);
        if (wide) return SYM_W'($urandom);
        return base ^ SYM_W'($urandom_range(0, 3));
    endfunction

    function automatic int pick_cost();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 255;
        if (r < 6) return $urandom_range(1, 4);
        return $urandom_range(0, 255);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic send_item(t_req req, logic [SYM_W-1:0] sym);
        int gap;
        gap = send_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= S_TDATA_W'(sym);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        model_item(req, sym);
        if (req != REQ_NOP) items_sent++;
    endtask

    // drop valid, drain all distances, then let a full target row finish
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (dist_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [VAL_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MAX_DIST: lim_dist = val;
            CFG_INS_COST: c_ins    = val[COST_W-1:0];
            CFG_DEL_COST: c_del    = val[COST_W-1:0];
            CFG_SUB_COST: c_sub    = val[COST_W-1:0];
            default: begin
            end
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // cost writes carry junk above the cost width; only the low byte counts
    task automatic set_regs(logic [VAL_W-1:0] lim, int ins, int del, int sub);
        write_reg(CFG_MAX_DIST, lim);
        write_reg(CFG_INS_COST, {HI_W'($urandom), COST_W'(ins)});
        write_reg(CFG_DEL_COST, {HI_W'($urandom), COST_W'(del)});
        write_reg(CFG_SUB_COST, {HI_W'($urandom), COST_W'(sub)});
    endtask

    task automatic run_job(int n_src, int n_tgt, bit wide, bit noisy);
        logic [SYM_W-1:0] base;
        base = SYM_W'($urandom);
        repeat (n_src) send_item(REQ_LOAD, pick_sym(base, wide));
        repeat (n_tgt) begin
            send_item(REQ_TARGET, pick_sym(base, wide));
            if (noisy && $urandom_range(0, 2) == 0)
                send_item($urandom_range(0, 1) ? REQ_NOP : REQ_LOAD, pick_sym(base, wide));
        end
        send_item(REQ_FINISH, SYM_W'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            i_m_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 12);
        end else begin
            i_m_tready <= 1'b0;
            ready_hold <= idle_len();
        end
    end

    always @(posedge i_clk) begin : result_check
        t_distance_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (dist_q.size() == 0) begin
                report_mismatch("unexpected result, distance", 32'(o_m_tdata[VAL_W-1:0]), 0);
            end else begin
                want = dist_q.pop_front();
                results_checked++;
                if (o_m_tdata[VAL_W-1:0] !== want.distance)
                    report_mismatch("distance", 32'(o_m_tdata[VAL_W-1:0]),
                                    32'(want.distance));
                if (o_m_tuser[0] !== want.cut)
                    report_mismatch("cut_off", 32'(o_m_tuser[0]), 32'(want.cut));
                if (o_m_tuser[1] !== want.over)
                    report_mismatch("source_overflow", 32'(o_m_tuser[1]), 32'(want.over));
            end
        end
    end

    task automatic test_unit_costs();
        send_item(REQ_FINISH, '0);
        send_item(REQ_LOAD, '0);
        send_item(REQ_LOAD, SYM_ALL);
        send_item(REQ_NOP, SYM_ALL);
        send_item(REQ_LOAD, SYM_W'(5));
        send_item(REQ_TARGET, '0);
        send_item(REQ_TARGET, SYM_W'(5));
        send_item(REQ_TARGET, SYM_ALL);
        send_item(REQ_TARGET, SYM_W'(7));
        send_item(REQ_FINISH, SYM_ALL);
    endtask

    task automatic test_empty_sides();
        // no target: distance is the source length
        repeat (4) send_item(REQ_LOAD, SYM_W'($urandom));
        send_item(REQ_FINISH, '0);
        // no source: first column only
        repeat (3) send_item(REQ_TARGET, SYM_W'($urandom));
        send_item(REQ_FINISH, '0);
    endtask

    task automatic test_late_load();
        send_item(REQ_LOAD, SYM_W'(9));
        send_item(REQ_TARGET, SYM_W'(9));
        send_item(REQ_LOAD, SYM_W'(3));
        send_item(REQ_TARGET, SYM_W'(3));
        send_item(REQ_FINISH, '0);
    endtask

    task automatic test_weighted_costs();
        settle();
        set_regs('0, 0, 255, 255);
        run_job(4, 4, 1'b0, 1'b0);
        settle();
        set_regs('0, 255, 0, 0);
        run_job(4, 5, 1'b0, 1'b0);
        settle();
        set_regs('0, 255, 255, 0);
        run_job(5, 3, 1'b0, 1'b0);
        settle();
        set_regs('0, 7, 3, 200);
        run_job(6, 6, 1'b0, 1'b0);
    endtask

    task automatic test_cutoff_clip();
        settle();
        set_regs(VAL_W'(2), 1, 1, 1);
        repeat (5) send_item(REQ_LOAD, SYM_W'($urandom));
        send_item(REQ_FINISH, '0);
        settle();
        set_regs(VAL_W'(1), 255, 255, 255);
        repeat (4) send_item(REQ_LOAD, SYM_W'($urandom_range(0, 3)));
        repeat (3) send_item(REQ_TARGET, SYM_W'(100));
        // held stopped: both ignored
        send_item(REQ_LOAD, SYM_W'(1));
        send_item(REQ_TARGET, SYM_W'(1));
        send_item(REQ_FINISH, '0);
        settle();
        set_regs(VAL_MAX, 255, 255, 255);
        run_job(4, 4, 1'b1, 1'b0);
    endtask

    // fill the source store, overrun it by one, then run a full-length row
    task automatic test_source_overflow();
        settle();
        set_regs('0, 1, 1, 1);
        repeat (MAX_LEN + 1) send_item(REQ_LOAD, SYM_W'($urandom_range(0, 3)));
        send_item(REQ_TARGET, SYM_W'($urandom_range(0, 3)));
        send_item(REQ_FINISH, '0);
    endtask

    task automatic test_random_jobs();
        int               first, r, n_src, n_tgt, jobs;
        logic [VAL_W-1:0] lim;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r < 4) lim = '0;
            else if (r < 7) lim = VAL_W'($urandom_range(1, 12));
            else if (r == 7) lim = VAL_MAX;
            else if (r == 8) lim = VAL_W'($urandom);
            else lim = VAL_W'(1);
            set_regs(lim, pick_cost(), pick_cost(), pick_cost());
            jobs = $urandom_range(3, 8);
            while (jobs > 0 && items_sent - first < RANDOM_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 85) n_src = $urandom_range(0, 10);
                else if (r < 98) n_src = $urandom_range(11, 40);
                else n_src = $urandom_range(41, 120);
                if ($urandom_range(0, 99) < 85) n_tgt = $urandom_range(0, 10);
                else n_tgt = $urandom_range(11, 30);
                run_job(n_src, n_tgt, $urandom_range(0, 3) == 0, $urandom_range(0, 6) == 0);
                jobs--;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unit_costs();
        test_empty_sides();
        test_late_load();
        test_weighted_costs();
        test_cutoff_clip();
        test_source_overflow();
        test_random_jobs();
        settle();
        $display("covered %0d input transactions over %0d register writes", items_sent,
                 reg_writes);
        $display("checked %0d distances: %0d stopped early, %0d with source overflow",
                 results_checked, cutoffs_seen, overflows_seen);
        if (errors == 0 && dist_q.size() == 0) begin
            $display("weighted_edit_distance_top regression: pass");
        end else begin
            $display("weighted_edit_distance_top regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
design/wed_pkg.sv
design/wed_cell.sv
design/weighted_edit_distance_top.sv
bench/tb_top.sv
